// File: src/boundary_ghost_point_iir_update_defines.svh
// Assertion macros for the boundary ghost point IIR update block.
// Used by the top level; needs a signal named clock and one named reset.
`ifndef BOUNDARY_GHOST_POINT_IIR_UPDATE_DEFINES_SVH
`define BOUNDARY_GHOST_POINT_IIR_UPDATE_DEFINES_SVH

// same-cycle implication
`define BGP_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define BGP_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: src/bgp_pkg.sv
// Shared types, constants and fixed point helpers for the boundary IIR block.
// No dependencies.
package bgp_pkg;

   localparam int DATA_W           = 32;
   localparam int IDX_W            = 10;
   localparam int CSR_IDX_W        = 3;
   localparam int WC_W             = 2;
   localparam int ENT_EXT_W        = 17;
   localparam int DEF_FILTER_ORDER = 2;
   localparam int DEF_NUM_ENTRIES  = 1024;

   localparam logic [CSR_IDX_W-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_A0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_A1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_A2 = 3'd5;

   localparam logic signed [31:0] ONE_Q28   = 32'sd268435456;
   localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;
   localparam logic signed [31:0] S32_MAX   = 32'sh7fffffff;
   localparam logic signed [31:0] S32_MIN   = 32'sh80000000;

   typedef struct packed {
      logic [IDX_W-1:0]         entry_index;
      logic signed [DATA_W-1:0] press_next;
      logic signed [DATA_W-1:0] press_prev;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] filter_output;
      logic                     ovf_flag;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic signed [64:0] numer;
      logic signed [31:0] denom;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic               sat;
      logic signed [31:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] val;
   } sat_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_MUL1, ST_RND1, ST_MUL2, ST_RND2,
      ST_DIV1, ST_WAIT1, ST_MUL3, ST_DIV2, ST_WAIT2,
      ST_FB_B, ST_FB_A, ST_FB_ACC, ST_WRITE, ST_FIN
   } state_type;

   // clamp to signed 32 bits, flag when clamped
   function automatic sat_type sat32(logic signed [65:0] v);
      sat_type r;
      r.hit = 1'b0;
      r.val = v[31:0];
      if (v > 66'sd2147483647) begin
         r.hit = 1'b1;
         r.val = S32_MAX;
      end else if (v < -66'sd2147483648) begin
         r.hit = 1'b1;
         r.val = S32_MIN;
      end
      return r;
   endfunction

   // round half up, then floor shift right by s
   function automatic logic signed [65:0] rnd(logic signed [63:0] p, int s);
      logic signed [65:0] e;
      e = $signed({{2{p[63]}}, p}) + (66'sd1 <<< (s - 1));
      return e >>> s;
   endfunction

endpackage

// File: src/bgp_div.sv
// Iterative signed divider, truncating, one quotient bit per cycle, saturating.
// Depends on bgp_pkg.
module bgp_div (
   input  logic                clock,
   input  logic                reset,
   input  bgp_pkg::div_req_type req,
   output bgp_pkg::div_rsp_type rsp
);
   import bgp_pkg::*;

   logic        busy_ff, busy_in, done_ff, done_in;
   logic        ovf_ff, ovf_in, neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in, low_ff, low_in, den_ff, den_in;
   logic [65:0] nneg;
   logic [64:0] nmag;
   logic [31:0] dmag;
   logic [32:0] trial, diff33;
   logic        qbit;
   logic signed [33:0] qs;
   sat_type     qsat;

   always_comb begin
      nneg = -$signed({req.numer[64], req.numer});
      nmag = req.numer[64] ? nneg[64:0] : req.numer;
      dmag = req.denom[31] ? 32'(-req.denom) : req.denom;
      trial  = {rem_ff, low_ff[31]};
      diff33 = trial - {1'b0, den_ff};
      qbit   = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      if (req.start) begin
         neg_in = req.numer[64] ^ req.denom[31];
         den_in = dmag;
         if (nmag >= {1'b0, dmag, 32'd0}) begin
            // quotient surely beyond 32 bits
            ovf_in  = 1'b1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            ovf_in  = 1'b0;
            rem_in  = nmag[63:32];
            low_in  = nmag[31:0];
            cnt_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (qbit) rem_in = diff33[31:0];
         else      rem_in = trial[31:0];
         low_in = {low_ff[30:0], qbit};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   always_comb begin
      qs   = neg_ff ? -$signed({2'b00, low_ff}) : $signed({2'b00, low_ff});
      qsat = sat32($signed({{32{qs[33]}}, qs}));
      rsp.done = done_ff;
      rsp.sat  = ovf_ff | qsat.hit;
      rsp.quot = ovf_ff ? (neg_ff ? S32_MIN : S32_MAX) : qsat.val;
   end

endmodule

// File: src/boundary_ghost_point_iir_update.sv
// Top level of the boundary ghost point IIR update block.
// Depends on bgp_pkg, bgp_div and boundary_ghost_point_iir_update_defines.svh.
//
// Usage:
// - req_* carries one item: entry index plus next and previous pressure (Q16.16).
//   An item is taken at a clock edge with req_valid high and req_stall low.
// - rsp_* returns one item per request: filter output (Q16.16) and a saturation
//   flag. The receiver holds it with rsp_stall; the result register keeps it.
// - csr_* writes the six Q4.28 coefficients (index b0,b1,b2,a0,a1,a2 = 0..5,
//   others ignored). csr_ready is always high; write only while idle.
// Timing:
// - Filtered item: check, two multiply and round steps, a divide, a multiply,
//   a second divide, a feedback round per stored word, write back and result;
//   each divide is a 32-step pass through the shared divider.
// - Skipped item (entry out of range, or equal pressures and word 0 zero):
//   result right after the check. The next item waits until the result loads.
// - One item at a time; req_stall is high while an item is in work. A new item
//   is taken while the previous result still waits on rsp_stall.
// Reset:
// - Coefficients return to b0 = a0 = 1.0, others 0. A clearing pass then zeros
//   the filter memory, one entry a cycle, with req_stall high.
// - Config writes are taken during the clearing pass.
`include "boundary_ghost_point_iir_update_defines.svh"

module boundary_ghost_point_iir_update #(
   parameter int FILTER_ORDER = bgp_pkg::DEF_FILTER_ORDER,
   parameter int NUM_ENTRIES  = bgp_pkg::DEF_NUM_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bgp_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bgp_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bgp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bgp_pkg::DATA_W-1:0]      csr_data
);
   import bgp_pkg::*;

   localparam int AW    = $clog2(NUM_ENTRIES);
   localparam int ROW_W = FILTER_ORDER * DATA_W;
   localparam int SH_W  = (FILTER_ORDER + 1) * DATA_W;

   // filter memory: one row of FILTER_ORDER words per entry
   logic [ROW_W-1:0] mem [NUM_ENTRIES];
   logic [ROW_W-1:0] rd_row_ff;
   logic             mem_we;
   logic [AW-1:0]    mem_wa, mem_ra;
   logic [ROW_W-1:0] mem_wd;

   state_type state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [WC_W-1:0] wc_ff, wc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic signed [31:0] b0_ff, b1_ff, b2_ff, a0_ff, a1_ff, a2_ff;

   req_type            req_ff, req_in;
   logic               inr_ff, inr_in;
   logic               err_ff, err_in;
   logic signed [31:0] delta_ff, delta_in, t_ff, t_in, x_ff, x_in, y_ff, y_in;
   logic signed [63:0] prod_ff;
   logic signed [65:0] acc_ff, acc_in;
   logic [SH_W-1:0]    old_ff, old_in, new_ff, new_in;

   logic signed [31:0] mul_a, mul_b, fs, sb0, da0, coef_bk, coef_ak, m1;
   logic [WC_W-1:0]    k;
   logic               in_acc, can_load;
   sat_type            s_d, s_r, s_t, s_x, s_v;
   logic signed [65:0] v;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   bgp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign in_acc    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign can_load  = !rsp_valid_ff || !rsp_stall;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= ONE_Q28;
         b1_ff <= '0;
         b2_ff <= '0;
         a0_ff <= ONE_Q28;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_B0:  b0_ff <= csr_data;
            REG_B1:  b1_ff <= csr_data;
            REG_B2:  b2_ff <= csr_data;
            REG_A0:  a0_ff <= csr_data;
            REG_A1:  a1_ff <= csr_data;
            REG_A2:  a2_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      // word 0 of the entry, loaded in the check step and held until feedback starts
      fs  = old_ff[DATA_W-1:0];
      sb0 = (b0_ff != 0) ? b0_ff : ONE_Q28;
      da0 = (a0_ff != 0) ? a0_ff : ONE_Q28;
      k   = wc_ff + WC_W'(1);
      unique case (k)
         2'd1:    begin coef_bk = b1_ff; coef_ak = a1_ff; end
         2'd2:    begin coef_bk = b2_ff; coef_ak = a2_ff; end
         default: begin coef_bk = '0;    coef_ak = '0;    end
      endcase
      m1  = old_ff[2*DATA_W-1:DATA_W];
      s_d = sat32(66'(req_ff.press_prev) - 66'(req_ff.press_next));
      s_r = sat32(rnd(prod_ff, 28));
      s_t = sat32(rnd(prod_ff, 30));
      s_x = sat32(-66'(div_rsp.quot));
      v   = acc_ff - rnd(prod_ff, 28) + 66'(m1);
      s_v = sat32(v);
   end

   // shared multiplier: operands picked by the sequencer
   always_comb begin
      unique case (state_ff)
         ST_MUL1: begin mul_a = a0_ff;   mul_b = delta_ff;  end
         ST_MUL2: begin mul_a = t_ff;    mul_b = SQRT3_Q30; end
         ST_MUL3: begin mul_a = x_ff;    mul_b = b0_ff;     end
         ST_FB_B: begin mul_a = coef_bk; mul_b = x_ff;      end
         ST_FB_A: begin mul_a = coef_ak; mul_b = y_ff;      end
         default: begin mul_a = '0;      mul_b = '0;        end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      wc_in        = wc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_in       = req_ff;
      inr_in       = inr_ff;
      err_in       = err_ff;
      delta_in     = delta_ff;
      t_in         = t_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      old_in       = old_ff;
      new_in       = new_ff;
      mem_we       = 1'b0;
      mem_wd       = new_ff[SH_W-1:DATA_W];
      mem_ra       = AW'(ENT_EXT_W'(req_data.entry_index));
      mem_wa       = AW'(ENT_EXT_W'(req_ff.entry_index));
      div_req.start = 1'b0;
      div_req.numer = $signed(65'(($signed(33'(t_ff)) + $signed(33'(fs))))) <<< 28;
      div_req.denom = sb0;
      if (state_ff == ST_DIV2) begin
         div_req.numer = 65'(prod_ff) + (65'(fs) <<< 28);
         div_req.denom = da0;
      end
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(NUM_ENTRIES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (in_acc) begin
               req_in   = req_data;
               inr_in   = ENT_EXT_W'(req_data.entry_index) < ENT_EXT_W'(NUM_ENTRIES);
               err_in   = 1'b0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            old_in   = {{DATA_W{1'b0}}, rd_row_ff};
            delta_in = s_d.val;
            wc_in    = '0;
            if (!inr_ff || (req_ff.press_prev == req_ff.press_next &&
                            rd_row_ff[DATA_W-1:0] == '0)) begin
               y_in     = '0;
               state_in = ST_FIN;
            end else begin
               err_in   = s_d.hit;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: state_in = ST_RND1;
         ST_RND1: begin
            t_in     = s_r.val;
            err_in   = err_ff | s_r.hit;
            state_in = ST_MUL2;
         end
         ST_MUL2: state_in = ST_RND2;
         ST_RND2: begin
            t_in     = s_t.val;
            err_in   = err_ff | s_t.hit;
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            div_req.start = 1'b1;
            state_in      = ST_WAIT1;
         end
         ST_WAIT1: begin
            if (div_rsp.done) begin
               x_in     = s_x.val;
               err_in   = err_ff | div_rsp.sat | s_x.hit;
               state_in = ST_MUL3;
            end
         end
         ST_MUL3: state_in = ST_DIV2;
         ST_DIV2: begin
            div_req.start = 1'b1;
            state_in      = ST_WAIT2;
         end
         ST_WAIT2: begin
            if (div_rsp.done) begin
               y_in     = div_rsp.quot;
               err_in   = err_ff | div_rsp.sat;
               state_in = ST_FB_B;
            end
         end
         ST_FB_B: state_in = ST_FB_A;
         ST_FB_A: begin
            acc_in   = rnd(prod_ff, 28);
            state_in = ST_FB_ACC;
         end
         ST_FB_ACC: begin
            // new word enters at the top; old words slide down
            new_in = {s_v.val, new_ff[SH_W-1:DATA_W]};
            old_in = {{DATA_W{1'b0}}, old_ff[SH_W-1:DATA_W]};
            err_in = err_ff | s_v.hit;
            wc_in  = wc_ff + WC_W'(1);
            if (wc_ff == WC_W'(FILTER_ORDER - 1)) state_in = ST_WRITE;
            else                                  state_in = ST_FB_B;
         end
         ST_WRITE: begin
            mem_we   = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (can_load) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.filter_output = y_ff;
               rsp_data_in.ovf_flag      = err_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wc_ff        <= wc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      req_ff      <= req_in;
      inr_ff      <= inr_in;
      err_ff      <= err_in;
      delta_ff    <= delta_in;
      t_ff        <= t_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      acc_ff      <= acc_in;
      old_ff      <= old_in;
      new_ff      <= new_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_row_ff <= mem[mem_ra];
   end

   `BGP_ASSERT_NEXT(a_accept_to_check, in_acc, state_ff == ST_CHECK, "item not checked")
   `BGP_ASSERT_NOW(a_div_done_waited, div_rsp.done,
      state_ff == ST_WAIT1 || state_ff == ST_WAIT2, "divider result unclaimed")
   `BGP_ASSERT_NEXT(a_fin_loads, state_ff == ST_FIN && can_load,
      rsp_valid_ff && state_ff == ST_IDLE, "result not loaded")
   `BGP_ASSERT_NOW(a_clear_blocks, state_ff == ST_CLEAR, req_stall && !rsp_valid_ff,
      "item taken during clear")

endmodule
